// ===== rtl/spb_pkg.sv =====
// shared constants and types for the sparse paged bit store
`timescale 1ns / 1ps
package spb_pkg;

    localparam int PAGE_SLOTS  = 64;
    localparam int STORE_WORDS = 4096;
    localparam int MAX_PAGE    = 4096;

    localparam int SLOT_W  = $clog2(PAGE_SLOTS);
    localparam int SCNT_W  = $clog2(PAGE_SLOTS + 1);
    localparam int WADDR_W = $clog2(STORE_WORDS);
    localparam int WCNT_W  = $clog2(STORE_WORDS + 1);

    localparam int INDEX_W = 48;
    localparam int PSIZE_W = 13;
    localparam int OFF_W   = 12;
    localparam int PAGES_W = 7;
    localparam int BITS_W  = 19;
    localparam int WORD_W  = 64;
    localparam int NEED_W  = 7;

    localparam int DIV_STEPS  = 4;
    localparam int DIV_CYC    = INDEX_W / DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYC);

    localparam int SLOT_DATA_W = INDEX_W + WADDR_W;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SEARCH,
        ST_DECIDE,
        ST_ZERO,
        ST_READ,
        ST_MODIFY,
        ST_FINISH
    } state_t;

endpackage

// ===== rtl/spb_if.sv =====
// handshake channel interfaces for requests, results and the page size register
`timescale 1ns / 1ps
interface spb_req_if;
    logic                            valid;
    logic                            ready;
    logic                            opcode;
    logic [spb_pkg::INDEX_W-1:0]     bit_pos;
    logic                            bit_value;
    modport source (output valid, opcode, bit_pos, bit_value, input ready);
    modport sink   (input valid, opcode, bit_pos, bit_value, output ready);
endinterface

interface spb_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            ok;
    logic                            read_value;
    logic [spb_pkg::PAGES_W-1:0]     pages_in_use;
    logic [spb_pkg::BITS_W-1:0]      physical_bit_count;
    logic [spb_pkg::BITS_W-1:0]      logical_bit_count;
    modport source (output valid, ok, read_value, pages_in_use, physical_bit_count,
                    logical_bit_count, input ready);
    modport sink   (input valid, ok, read_value, pages_in_use, physical_bit_count,
                    logical_bit_count, output ready);
endinterface

interface spb_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [spb_pkg::PSIZE_W-1:0]     page_size_bits;
    modport source (output valid, page_size_bits, input ready);
    modport sink   (input valid, page_size_bits, output ready);
endinterface

// ===== rtl/sparse_paged_bit_store.sv =====
// top level: page table search, word allocation and bit read-modify-write
// The block works on one item at a time. The remainder unit finds the page offset, the
// page table lives in a one-port ram and is scanned one slot a cycle, a hit then costs a
// read of the word store and, for a write, a write back to it, and a write of one to a new
// page zeroes its words one a cycle (ceil(page_size_bits/64) words, at most 64). A result
// register holds the finished word, so the next request is taken while it waits. Reset and
// a page size write free every page at once; word store contents are zeroed when a page is
// allocated, so no clearing pass runs.
`timescale 1ns / 1ps
module sparse_paged_bit_store (
    input  logic      clk,
    input  logic      rst_n,
    spb_req_if.sink   req,
    spb_rsp_if.source rsp,
    spb_cfg_if.sink   cfg
);

    spb_pkg::state_t state_reg, state_next;

    logic                             op_reg;
    logic [spb_pkg::INDEX_W-1:0]      idx_reg;
    logic                             val_reg;
    logic [spb_pkg::INDEX_W-1:0]      base_reg;
    logic [spb_pkg::OFF_W-1:0]        off_reg;
    logic [spb_pkg::SCNT_W-1:0]       cnt_reg, cnt_next;
    logic                             cmp_vld_reg, cmp_vld_next;
    logic [spb_pkg::SLOT_W-1:0]       cmp_idx_reg;
    logic                             hit_reg, hit_next;
    logic                             free_found_reg, free_found_next;
    logic [spb_pkg::SLOT_W-1:0]       free_idx_reg, free_idx_next;
    logic [spb_pkg::WADDR_W-1:0]      start_reg, start_next;
    logic                             ok_reg, ok_next;
    logic                             rd_reg, rd_next;
    logic [spb_pkg::NEED_W-1:0]       zcnt_reg, zcnt_next;

    logic [spb_pkg::PAGE_SLOTS-1:0]   slot_valid_reg, slot_valid_next;
    logic [spb_pkg::PAGES_W-1:0]      used_reg, used_next;
    logic [spb_pkg::WCNT_W-1:0]       words_reg, words_next;
    logic [spb_pkg::PSIZE_W-1:0]      page_reg;

    logic                             o_valid_reg, o_valid_next;
    logic                             o_ok_reg, o_rd_reg;
    logic [spb_pkg::PAGES_W-1:0]      o_pages_reg;
    logic [spb_pkg::BITS_W-1:0]       o_phys_reg, o_log_reg;
    logic                             o_load;

    logic                             div_start, div_done;
    logic [spb_pkg::PSIZE_W-1:0]      div_rem;

    logic                             slot_we;
    logic [spb_pkg::SLOT_W-1:0]       slot_addr;
    logic [spb_pkg::SLOT_DATA_W-1:0]  slot_wdata, slot_rdata;
    logic [spb_pkg::INDEX_W-1:0]      slot_rbase;
    logic [spb_pkg::WADDR_W-1:0]      slot_rstart;

    logic                             word_we;
    logic [spb_pkg::WADDR_W-1:0]      word_addr;
    logic [spb_pkg::WORD_W-1:0]       word_wdata, word_rdata, bit_mask;

    logic [spb_pkg::NEED_W-1:0]       need;
    logic [spb_pkg::PSIZE_W:0]        need_sum;
    logic                             room_ok;
    logic [spb_pkg::PSIZE_W-1:0]      cfg_eff;
    logic [spb_pkg::PAGES_W+spb_pkg::PSIZE_W-1:0] log_prod;

    assign need_sum   = {1'b0, page_reg} + (spb_pkg::PSIZE_W+1)'(63);
    assign need       = need_sum[spb_pkg::PSIZE_W-1:6];
    assign room_ok    = ({1'b0, words_reg} + (spb_pkg::WCNT_W+1)'(need))
                        <= (spb_pkg::WCNT_W+1)'(spb_pkg::STORE_WORDS);
    assign bit_mask   = spb_pkg::WORD_W'(1) << off_reg[5:0];
    assign slot_rbase = slot_rdata[spb_pkg::SLOT_DATA_W-1:spb_pkg::WADDR_W];
    assign slot_rstart = slot_rdata[spb_pkg::WADDR_W-1:0];
    assign log_prod   = used_reg * page_reg;

    // zero or out of range page size means the largest page
    assign cfg_eff = (cfg.page_size_bits == '0 ||
                      cfg.page_size_bits > spb_pkg::PSIZE_W'(spb_pkg::MAX_PAGE))
                     ? spb_pkg::PSIZE_W'(spb_pkg::MAX_PAGE) : cfg.page_size_bits;

    assign req.ready = (state_reg == spb_pkg::ST_IDLE);
    assign cfg.ready = 1'b1;
    assign div_start = req.valid && req.ready;

    spb_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (req.bit_pos),
        .divisor  (page_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    spb_ram #(
        .WIDTH (spb_pkg::SLOT_DATA_W),
        .DEPTH (spb_pkg::PAGE_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .addr  (slot_addr),
        .wdata (slot_wdata),
        .rdata (slot_rdata)
    );

    spb_ram #(
        .WIDTH (spb_pkg::WORD_W),
        .DEPTH (spb_pkg::STORE_WORDS)
    ) u_word_ram (
        .clk   (clk),
        .we    (word_we),
        .addr  (word_addr),
        .wdata (word_wdata),
        .rdata (word_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        cmp_vld_next    = 1'b0;
        hit_next        = hit_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        start_next      = start_reg;
        ok_next         = ok_reg;
        rd_next         = rd_reg;
        zcnt_next       = zcnt_reg;
        slot_valid_next = slot_valid_reg;
        used_next       = used_reg;
        words_next      = words_reg;
        o_valid_next    = o_valid_reg;
        o_load          = 1'b0;
        slot_we         = 1'b0;
        slot_addr       = free_idx_reg;
        slot_wdata      = {base_reg, words_reg[spb_pkg::WADDR_W-1:0]};
        word_we         = 1'b0;
        word_addr       = start_reg + spb_pkg::WADDR_W'(off_reg[spb_pkg::OFF_W-1:6]);
        word_wdata      = op_reg == spb_pkg::OP_WRITE && val_reg ? (word_rdata | bit_mask)
                                                                 : (word_rdata & ~bit_mask);

        if (rsp.valid && rsp.ready)
        begin
            o_valid_next = 1'b0;
        end

        case (state_reg)
            spb_pkg::ST_IDLE:
            begin
                if (div_start)
                begin
                    state_next = spb_pkg::ST_DIV;
                end
            end
            spb_pkg::ST_DIV:
            begin
                cnt_next        = '0;
                hit_next        = 1'b0;
                free_found_next = 1'b0;
                ok_next         = 1'b1;
                rd_next         = 1'b0;
                if (div_done)
                begin
                    state_next = spb_pkg::ST_SEARCH;
                end
            end
            spb_pkg::ST_SEARCH:
            begin
                slot_addr = cnt_reg[spb_pkg::SLOT_W-1:0];
                if (cnt_reg != spb_pkg::SCNT_W'(spb_pkg::PAGE_SLOTS))
                begin
                    cnt_next     = cnt_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                end
                if (cmp_vld_reg)
                begin
                    if (slot_valid_reg[cmp_idx_reg] && slot_rbase == base_reg)
                    begin
                        hit_next   = 1'b1;
                        start_next = slot_rstart;
                    end
                    if (!slot_valid_reg[cmp_idx_reg] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = cmp_idx_reg;
                    end
                end
                else if (cnt_reg == spb_pkg::SCNT_W'(spb_pkg::PAGE_SLOTS))
                begin
                    state_next = spb_pkg::ST_DECIDE;
                end
            end
            spb_pkg::ST_DECIDE:
            begin
                if (hit_reg)
                begin
                    state_next = spb_pkg::ST_READ;
                end
                else if (op_reg == spb_pkg::OP_READ || !val_reg)
                begin
                    state_next = spb_pkg::ST_FINISH;
                end
                else if (!free_found_reg || !room_ok)
                begin
                    ok_next    = 1'b0;
                    state_next = spb_pkg::ST_FINISH;
                end
                else
                begin
                    slot_we                       = 1'b1;
                    slot_valid_next[free_idx_reg] = 1'b1;
                    used_next                     = used_reg + 1'b1;
                    start_next                    = words_reg[spb_pkg::WADDR_W-1:0];
                    words_next                    = words_reg + spb_pkg::WCNT_W'(need);
                    zcnt_next                     = '0;
                    state_next                    = spb_pkg::ST_ZERO;
                end
            end
            spb_pkg::ST_ZERO:
            begin
                // fresh page words are cleared, the written bit goes in on the way
                word_we    = 1'b1;
                word_addr  = start_reg + spb_pkg::WADDR_W'(zcnt_reg);
                word_wdata = (zcnt_reg[5:0] == off_reg[spb_pkg::OFF_W-1:6]) ? bit_mask : '0;
                zcnt_next  = zcnt_reg + 1'b1;
                if (zcnt_reg == need - 1'b1)
                begin
                    state_next = spb_pkg::ST_FINISH;
                end
            end
            spb_pkg::ST_READ:
            begin
                state_next = spb_pkg::ST_MODIFY;
            end
            spb_pkg::ST_MODIFY:
            begin
                if (op_reg == spb_pkg::OP_READ)
                begin
                    rd_next = word_rdata[off_reg[5:0]];
                end
                else
                begin
                    word_we = 1'b1;
                end
                state_next = spb_pkg::ST_FINISH;
            end
            spb_pkg::ST_FINISH:
            begin
                if (!o_valid_reg || rsp.ready)
                begin
                    o_load       = 1'b1;
                    o_valid_next = 1'b1;
                    state_next   = spb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = spb_pkg::ST_IDLE;
            end
        endcase

        if (cfg.valid)
        begin
            slot_valid_next = '0;
            used_next       = '0;
            words_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= spb_pkg::ST_IDLE;
            cnt_reg        <= '0;
            cmp_vld_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            zcnt_reg       <= '0;
            slot_valid_reg <= '0;
            used_reg       <= '0;
            words_reg      <= '0;
            page_reg       <= spb_pkg::PSIZE_W'(spb_pkg::MAX_PAGE);
            o_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            cmp_vld_reg    <= cmp_vld_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
            zcnt_reg       <= zcnt_next;
            slot_valid_reg <= slot_valid_next;
            used_reg       <= used_next;
            words_reg      <= words_next;
            o_valid_reg    <= o_valid_next;
            if (cfg.valid)
            begin
                page_reg <= cfg_eff;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= cnt_reg[spb_pkg::SLOT_W-1:0];
        free_idx_reg <= free_idx_next;
        start_reg    <= start_next;
        ok_reg       <= ok_next;
        rd_reg       <= rd_next;
        if (div_start)
        begin
            op_reg  <= req.opcode;
            idx_reg <= req.bit_pos;
            val_reg <= req.bit_value;
        end
        if (div_done)
        begin
            base_reg <= idx_reg - spb_pkg::INDEX_W'(div_rem);
            off_reg  <= div_rem[spb_pkg::OFF_W-1:0];
        end
        if (o_load)
        begin
            o_ok_reg    <= ok_reg;
            o_rd_reg    <= rd_reg;
            o_pages_reg <= used_reg;
            o_phys_reg  <= spb_pkg::BITS_W'({words_reg, 6'b0});
            o_log_reg   <= log_prod[spb_pkg::BITS_W-1:0];
        end
    end

    assign rsp.valid              = o_valid_reg;
    assign rsp.ok                 = o_ok_reg;
    assign rsp.read_value         = o_rd_reg;
    assign rsp.pages_in_use       = o_pages_reg;
    assign rsp.physical_bit_count = o_phys_reg;
    assign rsp.logical_bit_count  = o_log_reg;

endmodule

// ===== rtl/spb_ram.sv =====
// generic single port ram with registered read
`timescale 1ns / 1ps
module spb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/spb_rem.sv =====
// iterative remainder unit: bit index modulo the page size, several bits a cycle
`timescale 1ns / 1ps
module spb_rem (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [spb_pkg::INDEX_W-1:0]   dividend,
    input  logic [spb_pkg::PSIZE_W-1:0]   divisor,
    output logic                          done,
    output logic [spb_pkg::PSIZE_W-1:0]   rem
);

    logic [spb_pkg::INDEX_W-1:0]   q_reg, q_next;
    logic [spb_pkg::PSIZE_W-1:0]   r_reg, r_next;
    logic [spb_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;

    always_comb
    begin
        logic [spb_pkg::PSIZE_W:0] t;
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        t         = '0;
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < spb_pkg::DIV_STEPS; i++)
            begin
                t      = {r_next, q_next[spb_pkg::INDEX_W-1]};
                q_next = {q_next[spb_pkg::INDEX_W-2:0], 1'b0};
                if (t >= {1'b0, divisor})
                begin
                    t = t - {1'b0, divisor};
                end
                r_next = t[spb_pkg::PSIZE_W-1:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == spb_pkg::DIV_CNT_W'(spb_pkg::DIV_CYC - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign done = done_reg;
    assign rem  = r_reg;

endmodule

// ===== rtl/spb_checker.sv =====
// port level checks on the result channel, bound to the top level
`timescale 1ns / 1ps
module spb_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic                         rsp_ok,
    input logic                         rsp_read_value,
    input logic [spb_pkg::PAGES_W-1:0]  rsp_pages_in_use,
    input logic [spb_pkg::BITS_W-1:0]   rsp_physical_bit_count,
    input logic [spb_pkg::BITS_W-1:0]   rsp_logical_bit_count
);

    // a stalled result holds its valid, ok, read value and page count
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) &&
        $stable(rsp_read_value) && $stable(rsp_pages_in_use))
        else $error("result word changed while stalled");

    // a failed write never reports a read bit
    a_fail_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ok |-> !rsp_read_value)
        else $error("failed write returned a read bit");

    // no pages means no allocated bits
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_pages_in_use == '0 |->
        rsp_physical_bit_count == '0 && rsp_logical_bit_count == '0)
        else $error("bit counts without pages");

    a_slot_limit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_pages_in_use <= spb_pkg::PAGES_W'(spb_pkg::PAGE_SLOTS))
        else $error("pages in use above slot count");

endmodule

bind sparse_paged_bit_store spb_checker u_spb_checker (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .rsp_valid              (rsp.valid),
    .rsp_ready              (rsp.ready),
    .rsp_ok                 (rsp.ok),
    .rsp_read_value         (rsp.read_value),
    .rsp_pages_in_use       (rsp.pages_in_use),
    .rsp_physical_bit_count (rsp.physical_bit_count),
    .rsp_logical_bit_count  (rsp.logical_bit_count)
);
